// ===== hw/rtl/msb_first_bit_packer_with_stuffing_assert.svh =====
// Assertion macros shared by the checker of the bit packer.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MSB_FIRST_BIT_PACKER_WITH_STUFFING_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_WITH_STUFFING_ASSERT_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define MBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbp check failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define MBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbp check failed");

`endif

// ===== hw/rtl/mbp_pkg.sv =====
// Shared constants, codes and helper functions of the MSB-first bit packer.
// No dependencies; used by the item and result interfaces and all modules.
`default_nettype none

package mbp_pkg;

    localparam int CODE_W            = 16;
    localparam int COUNT_W           = 5;
    localparam int BYTE_W            = 8;
    localparam int MAX_PUSH_BITS_DEF = 16;

    localparam logic [BYTE_W-1:0] STUFF_MARK = 8'hFF;
    localparam logic [BYTE_W-1:0] STUFF_FILL = 8'h00;

    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_ALIGN = 1'b1;

    // Effective push length: the parameter is capped by the code field width.
    function automatic int push_limit(input int max_push_bits);
        return (max_push_bits < CODE_W) ? max_push_bits : CODE_W;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mbp_cfg_if.sv =====
// Configuration write channel carrying the stuffing enable.
// Depends on nothing outside this file.
`default_nettype none

interface mbp_cfg_if;
    logic valid;
    logic ready;
    logic stuff_enable;

    modport source (output valid, output stuff_enable, input ready);
    modport sink (input valid, input stuff_enable, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbp_in_if.sv =====
// Input item channel: push or align command with its code bits.
// Depends on mbp_pkg for field widths.
`default_nettype none

interface mbp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [mbp_pkg::CODE_W-1:0]    code_bits;
    logic [mbp_pkg::COUNT_W-1:0]   bit_count;

    modport source (output valid, output func, output code_bits, output bit_count,
                    input ready);
    modport sink (input valid, input func, input code_bits, input bit_count,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbp_out_if.sv =====
// Output byte channel: one packed byte per word, with an end-of-item flag.
// Depends on mbp_pkg for field widths.
`default_nettype none

interface mbp_out_if;
    logic                         valid;
    logic                         ready;
    logic [mbp_pkg::BYTE_W-1:0]   out_byte;
    logic                         last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mbp_pack.sv =====
// Packing stage: merges each item with the partial byte and registers the
// completed bytes as one group. Depends on mbp_pkg and mbp_in_if.
`default_nettype none

module mbp_pack #(
    parameter int MAX_PUSH_BITS = mbp_pkg::MAX_PUSH_BITS_DEF,
    localparam int LIMIT = mbp_pkg::push_limit(MAX_PUSH_BITS),
    localparam int ACC_W = mbp_pkg::BYTE_W - 1 + LIMIT,
    localparam int NB    = ACC_W / mbp_pkg::BYTE_W,
    localparam int CNT_W = $clog2(NB + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mbp_in_if.sink                             item,
    output logic                               grp_valid,
    input  wire logic                          grp_take,
    output logic [mbp_pkg::BYTE_W-1:0]         grp_bytes [NB],
    output logic [CNT_W-1:0]                   grp_cnt
);

    localparam int BW    = mbp_pkg::BYTE_W;
    localparam int TOT_W = $clog2(ACC_W + 1);
    localparam logic [mbp_pkg::COUNT_W-1:0] LIMIT_C = mbp_pkg::COUNT_W'(LIMIT);
    localparam logic [3:0] BYTE_C = 4'(BW);

    logic [BW-1:0]    partial_reg, partial_next;
    logic [2:0]       pcount_reg, pcount_next;
    logic             grp_valid_reg, grp_valid_next;
    logic [BW-1:0]    grp_bytes_reg [NB];
    logic [BW-1:0]    grp_bytes_next [NB];
    logic [CNT_W-1:0] grp_cnt_reg, grp_cnt_next;

    logic                         item_acc;
    logic [mbp_pkg::COUNT_W-1:0]  cnt_sat;
    logic [mbp_pkg::CODE_W-1:0]   code_mask;
    logic [ACC_W-1:0]             pval;
    logic [ACC_W-1:0]             acc;
    logic [TOT_W-1:0]             total;
    logic [TOT_W-1:0]             shamt;
    logic [2:0]                   rem;
    logic [CNT_W-1:0]             nbytes;

    assign item_acc  = item.valid && item.ready;
    // The group register can refill in the cycle its bytes move to the emit stage.
    assign item.ready = !grp_valid_reg || grp_take;

    always_comb
    begin
        cnt_sat   = (item.bit_count > LIMIT_C) ? LIMIT_C : item.bit_count;
        code_mask = ~({mbp_pkg::CODE_W{1'b1}} << cnt_sat);
        // Pending bits, right aligned, then shifted up to make room for the code.
        pval  = ACC_W'(partial_reg) >> (BYTE_C - {1'b0, pcount_reg});
        acc   = (pval << cnt_sat) | ACC_W'(item.code_bits & code_mask);
        total = TOT_W'(pcount_reg) + TOT_W'(cnt_sat);
        rem   = total[2:0];
        shamt = '0;

        partial_next   = partial_reg;
        pcount_next    = pcount_reg;
        grp_valid_next = grp_valid_reg;
        grp_cnt_next   = grp_cnt_reg;
        nbytes         = '0;
        for (int i = 0; i < NB; i++)
        begin
            grp_bytes_next[i] = grp_bytes_reg[i];
        end

        if (grp_take)
        begin
            grp_valid_next = 1'b0;
        end

        if (item_acc)
        begin
            if (item.func == mbp_pkg::FUNC_ALIGN)
            begin
                if (pcount_reg != 3'd0)
                begin
                    nbytes            = CNT_W'(1);
                    grp_bytes_next[0] = partial_reg;
                end
                partial_next = '0;
                pcount_next  = 3'd0;
            end
            else
            begin
                nbytes = CNT_W'(total >> 3);
                for (int i = 0; i < NB; i++)
                begin
                    shamt = total - TOT_W'(BW * (i + 1));
                    if (CNT_W'(i) < nbytes)
                    begin
                        grp_bytes_next[i] = BW'(acc >> shamt);
                    end
                end
                // Leftover low bits move to the top of the partial byte.
                partial_next = BW'(acc << (BYTE_C - {1'b0, rem}));
                pcount_next  = rem;
            end
            grp_valid_next = (nbytes != '0);
            grp_cnt_next   = nbytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            pcount_reg    <= 3'd0;
            grp_valid_reg <= 1'b0;
            grp_cnt_reg   <= '0;
        end
        else
        begin
            partial_reg   <= partial_next;
            pcount_reg    <= pcount_next;
            grp_valid_reg <= grp_valid_next;
            grp_cnt_reg   <= grp_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NB; i++)
        begin
            grp_bytes_reg[i] <= grp_bytes_next[i];
        end
    end

    assign grp_valid = grp_valid_reg;
    assign grp_cnt   = grp_cnt_reg;
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            grp_bytes[i] = grp_bytes_reg[i];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_emit.sv =====
// Emit stage: sends the bytes of one group a word per cycle, while the output is
// not stalled, through an output register, inserting a zero byte after 0xFF when
// stuffing is on. Depends on mbp_pkg and mbp_out_if.
`default_nettype none

module mbp_emit #(
    parameter int MAX_PUSH_BITS = mbp_pkg::MAX_PUSH_BITS_DEF,
    localparam int LIMIT = mbp_pkg::push_limit(MAX_PUSH_BITS),
    localparam int ACC_W = mbp_pkg::BYTE_W - 1 + LIMIT,
    localparam int NB    = ACC_W / mbp_pkg::BYTE_W,
    localparam int CNT_W = $clog2(NB + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          stuff_enable,
    input  wire logic                          grp_valid,
    output logic                               grp_take,
    input  wire logic [mbp_pkg::BYTE_W-1:0]    grp_bytes [NB],
    input  wire logic [CNT_W-1:0]              grp_cnt,
    mbp_out_if.source                          result
);

    localparam int BW = mbp_pkg::BYTE_W;

    logic             cur_valid_reg, cur_valid_next;
    logic [BW-1:0]    cur_bytes_reg [NB];
    logic [BW-1:0]    cur_bytes_next [NB];
    logic [CNT_W-1:0] cur_rem_reg, cur_rem_next;
    logic             stuff_pend_reg, stuff_pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [BW-1:0]    out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    logic          out_free;
    logic          step;
    logic          need_stuff;
    logic          emit_last;
    logic [BW-1:0] emit_byte;
    logic          load;

    always_comb
    begin
        out_free   = !out_valid_reg || result.ready;
        step       = cur_valid_reg && out_free;
        need_stuff = stuff_enable && (cur_bytes_reg[0] == mbp_pkg::STUFF_MARK);

        if (stuff_pend_reg)
        begin
            emit_byte = mbp_pkg::STUFF_FILL;
            emit_last = (cur_rem_reg == '0);
        end
        else
        begin
            emit_byte = cur_bytes_reg[0];
            emit_last = (cur_rem_reg == CNT_W'(1)) && !need_stuff;
        end

        // A new group comes in as the last word of the current one goes out, or when none is held.
        load = grp_valid && (!cur_valid_reg || (step && emit_last));

        cur_valid_next  = cur_valid_reg;
        cur_rem_next    = cur_rem_reg;
        stuff_pend_next = stuff_pend_reg;
        for (int i = 0; i < NB; i++)
        begin
            cur_bytes_next[i] = cur_bytes_reg[i];
        end

        if (step)
        begin
            if (stuff_pend_reg)
            begin
                stuff_pend_next = 1'b0;
            end
            else
            begin
                cur_rem_next    = cur_rem_reg - CNT_W'(1);
                stuff_pend_next = need_stuff;
                for (int i = 0; i < NB - 1; i++)
                begin
                    cur_bytes_next[i] = cur_bytes_reg[i + 1];
                end
            end
            if (emit_last)
            begin
                cur_valid_next = 1'b0;
            end
        end

        if (load)
        begin
            cur_valid_next  = 1'b1;
            cur_rem_next    = grp_cnt;
            stuff_pend_next = 1'b0;
            for (int i = 0; i < NB; i++)
            begin
                cur_bytes_next[i] = grp_bytes[i];
            end
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            cur_rem_reg    <= '0;
            stuff_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_valid_reg  <= cur_valid_next;
            cur_rem_reg    <= cur_rem_next;
            stuff_pend_reg <= stuff_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NB; i++)
        begin
            cur_bytes_reg[i] <= cur_bytes_next[i];
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign grp_take        = load;
    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/msb_first_bit_packer_with_stuffing.sv =====
// Top level of the MSB-first bit packer with optional 0xFF byte stuffing.
// Depends on mbp_pkg, the three channel interfaces, mbp_pack and mbp_emit.
//
//   Channel  Side  Word carries
//   -------  ----  -------------------------------------------
//   cfg      sink  stuff_enable (write only, always ready)
//   item     sink  func, code_bits, bit_count
//   result   out   out_byte, last
//
// An item is accepted in any cycle in which the group register is empty or hands
// its group to the emit stage, so items can follow back to back. Bytes leave one
// per cycle while result is not stalled; an item yields N words, N being its bytes
// plus stuffed zeros (0 to 4). The bytes of an item pass through the group
// register, the current group register of the emit stage and the output register.
// Reset empties the partial byte, clears all valid flags and turns stuffing off.
// A stall on result holds the output register and then backs up into item.
`default_nettype none

module msb_first_bit_packer_with_stuffing #(
    parameter int MAX_PUSH_BITS = mbp_pkg::MAX_PUSH_BITS_DEF,
    localparam int LIMIT = mbp_pkg::push_limit(MAX_PUSH_BITS),
    localparam int ACC_W = mbp_pkg::BYTE_W - 1 + LIMIT,
    localparam int NB    = ACC_W / mbp_pkg::BYTE_W,
    localparam int CNT_W = $clog2(NB + 1)
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mbp_cfg_if.sink    cfg,
    mbp_in_if.sink     item,
    mbp_out_if.source  result
);

    logic                       stuff_enable_reg, stuff_enable_next;
    logic                       grp_valid;
    logic                       grp_take;
    logic [mbp_pkg::BYTE_W-1:0] grp_bytes [NB];
    logic [CNT_W-1:0]           grp_cnt;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        stuff_enable_next = stuff_enable_reg;
        if (cfg.valid && cfg.ready)
        begin
            stuff_enable_next = cfg.stuff_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuff_enable_reg <= 1'b0;
        end
        else
        begin
            stuff_enable_reg <= stuff_enable_next;
        end
    end

    mbp_pack #(
        .MAX_PUSH_BITS (MAX_PUSH_BITS)
    ) u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .grp_valid (grp_valid),
        .grp_take  (grp_take),
        .grp_bytes (grp_bytes),
        .grp_cnt   (grp_cnt)
    );

    mbp_emit #(
        .MAX_PUSH_BITS (MAX_PUSH_BITS)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .stuff_enable (stuff_enable_reg),
        .grp_valid    (grp_valid),
        .grp_take     (grp_take),
        .grp_bytes    (grp_bytes),
        .grp_cnt      (grp_cnt),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mbp_checker.sv =====
// Port-level checker of the bit packer, bound to the top level below.
// Depends on mbp_pkg and the assertion macro header.
`default_nettype none
`include "msb_first_bit_packer_with_stuffing_assert.svh"

module mbp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic                        cfg_stuff_enable,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic [mbp_pkg::BYTE_W-1:0]  res_out_byte,
    input wire logic                        res_last
);

    logic stuff_reg, stuff_next;
    logic expect_zero_reg, expect_zero_next;
    logic res_acc;
    logic res_stall;
    logic res_mark;
    logic res_fill;
    logic [mbp_pkg::BYTE_W:0] res_word;

    assign res_acc   = res_valid && res_ready;
    assign res_stall = res_valid && !res_ready;
    assign res_word  = {res_out_byte, res_last};
    assign res_mark  = res_acc && stuff_reg && (res_out_byte == mbp_pkg::STUFF_MARK);
    assign res_fill  = (res_out_byte == mbp_pkg::STUFF_FILL);

    always_comb
    begin
        stuff_next       = stuff_reg;
        expect_zero_next = expect_zero_reg;
        if (cfg_valid && cfg_ready)
        begin
            stuff_next = cfg_stuff_enable;
        end
        if (res_acc)
        begin
            expect_zero_next = stuff_reg && (res_out_byte == mbp_pkg::STUFF_MARK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stuff_reg       <= 1'b0;
            expect_zero_reg <= 1'b0;
        end
        else
        begin
            stuff_reg       <= stuff_next;
            expect_zero_reg <= expect_zero_next;
        end
    end

    // A stalled word holds its contents.
    `MBP_ASSERT_NEXT(a_res_hold, clk, rst_n, res_stall, res_valid && $stable(res_word))

    // With stuffing on, 0xFF is never the final word of an item.
    `MBP_ASSERT_IMP(a_mark_not_last, clk, rst_n, res_mark, !res_last)

    // The word after a stuffed 0xFF is the zero fill byte.
    `MBP_ASSERT_IMP(a_fill_follows, clk, rst_n, res_acc && expect_zero_reg, res_fill)

endmodule

bind msb_first_bit_packer_with_stuffing mbp_checker u_mbp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg.valid),
    .cfg_ready        (cfg.ready),
    .cfg_stuff_enable (cfg.stuff_enable),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_out_byte     (result.out_byte),
    .res_last         (result.last)
);

`default_nettype wire

// ===== tb/msb_first_bit_packer_with_stuffing_tb.sv =====
// Self-checking testbench for the MSB-first bit packer with 0xFF byte stuffing.
// Depends on mbp_pkg, the three channel interfaces and the packer top level.
`default_nettype none

module msb_first_bit_packer_with_stuffing_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PUSH_LIMIT    = mbp_pkg::push_limit(mbp_pkg::MAX_PUSH_BITS_DEF);

    typedef struct packed {
        logic [mbp_pkg::BYTE_W-1:0] out_byte;
        logic                       last;
    } packed_byte_t;

    logic clk;
    logic rst_n;

    mbp_cfg_if cfg_ch();
    mbp_in_if  item_ch();
    mbp_out_if result_ch();

    msb_first_bit_packer_with_stuffing dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predictor state, mirrored from the accepted traffic.
    logic [mbp_pkg::BYTE_W-1:0] pending_bits;
    int unsigned                pending_count;
    logic                       stuff_on;

    packed_byte_t expected_bytes[$];
    int           error_count;
    int           cycle_count;
    int           sender_idle_pct;
    int           receiver_stall_pct;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare every accepted byte against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected word: out_byte %h last %b",
                       result_ch.out_byte, result_ch.last);
                error_count++;
            end
            else
            begin
                packed_byte_t exp_word;
                exp_word = expected_bytes.pop_front();
                if (result_ch.out_byte !== exp_word.out_byte)
                begin
                    $error("out_byte mismatch: expected %h, actual %h",
                           exp_word.out_byte, result_ch.out_byte);
                    error_count++;
                end
                if (result_ch.last !== exp_word.last)
                begin
                    $error("last mismatch: expected %b, actual %b",
                           exp_word.last, result_ch.last);
                    error_count++;
                end
            end
        end
    end

    function automatic void queue_byte(input logic [mbp_pkg::BYTE_W-1:0] b,
                                       ref packed_byte_t group[$]);
        packed_byte_t w;
        w.out_byte = b;
        w.last     = 1'b0;
        group.insert(group.size(), w);
        if (stuff_on && b == mbp_pkg::STUFF_MARK)
        begin
            w.out_byte = mbp_pkg::STUFF_FILL;
            group.insert(group.size(), w);
        end
    endfunction

    function automatic void predict_bytes(input logic f,
                                          input logic [mbp_pkg::CODE_W-1:0] code,
                                          input logic [mbp_pkg::COUNT_W-1:0] cnt);
        packed_byte_t group[$];
        logic [31:0]  acc;
        logic [31:0]  mask;
        int unsigned  used;
        int unsigned  total;
        if (f == mbp_pkg::FUNC_ALIGN)
        begin
            if (pending_count > 0)
            begin
                queue_byte(pending_bits, group);
                pending_bits  = '0;
                pending_count = 0;
            end
        end
        else
        begin
            used  = (cnt > PUSH_LIMIT) ? PUSH_LIMIT : cnt;
            mask  = (32'd1 << used) - 32'd1;
            acc   = ((32'(pending_bits) >> (mbp_pkg::BYTE_W - pending_count)) << used)
                    | (32'(code) & mask);
            total = pending_count + used;
            while (total >= mbp_pkg::BYTE_W)
            begin
                queue_byte(8'(acc >> (total - mbp_pkg::BYTE_W)), group);
                total -= mbp_pkg::BYTE_W;
            end
            acc           = acc & ((32'd1 << total) - 32'd1);
            pending_bits  = 8'(acc << (mbp_pkg::BYTE_W - total));
            pending_count = total;
        end
        if (group.size() > 0)
            group[group.size() - 1].last = 1'b1;
        foreach (group[i])
            expected_bytes.insert(expected_bytes.size(), group[i]);
    endfunction

    // Offer one item, possibly after an idle gap, and hold it until accepted.
    // Valid stays high afterwards so back-to-back items need no extra step.
    task automatic send_code(input logic f, input logic [mbp_pkg::CODE_W-1:0] code,
                             input logic [mbp_pkg::COUNT_W-1:0] cnt);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid     <= 1'b1;
        item_ch.func      <= f;
        item_ch.code_bits <= code;
        item_ch.bit_count <= cnt;
        do @(posedge clk); while (!item_ch.ready);
        predict_bytes(f, code, cnt);
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        // An item with no bytes may still be in flight; give it time to settle.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_stuffing(input logic en);
        drain_results();
        @(negedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.stuff_enable <= en;
        do @(posedge clk); while (!cfg_ch.ready);
        stuff_on = en;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_directed_packing();
        write_stuffing(1'b0);
        send_code(mbp_pkg::FUNC_PUSH, 16'hFFFF, 5'd0);
        send_code(mbp_pkg::FUNC_PUSH, 16'hFFA5, 5'd8);
        send_code(mbp_pkg::FUNC_PUSH, 16'hFFFF, 5'd16);
        send_code(mbp_pkg::FUNC_PUSH, 16'h0001, 5'd1);
        send_code(mbp_pkg::FUNC_ALIGN, 16'h0000, 5'd0);
        send_code(mbp_pkg::FUNC_ALIGN, 16'hFFFF, 5'd31);
        send_code(mbp_pkg::FUNC_PUSH, 16'h0000, 5'd16);
        send_code(mbp_pkg::FUNC_PUSH, 16'h007F, 5'd7);
        send_code(mbp_pkg::FUNC_PUSH, 16'hBEEF, 5'd17);
        send_code(mbp_pkg::FUNC_PUSH, 16'h1234, 5'd31);
        send_code(mbp_pkg::FUNC_PUSH, 16'h0003, 5'd3);
        send_code(mbp_pkg::FUNC_ALIGN, 16'h0000, 5'd0);
    endtask

    task automatic test_directed_stuffing();
        write_stuffing(1'b1);
        send_code(mbp_pkg::FUNC_PUSH, 16'hFFFF, 5'd16);
        send_code(mbp_pkg::FUNC_PUSH, 16'h000F, 5'd4);
        send_code(mbp_pkg::FUNC_PUSH, 16'h000F, 5'd4);
        send_code(mbp_pkg::FUNC_PUSH, 16'h007F, 5'd7);
        send_code(mbp_pkg::FUNC_PUSH, 16'hFFFF, 5'd16);
        send_code(mbp_pkg::FUNC_ALIGN, 16'h0000, 5'd0);
        send_code(mbp_pkg::FUNC_PUSH, 16'h00FE, 5'd8);
        send_code(mbp_pkg::FUNC_PUSH, 16'h0000, 5'd0);
        send_code(mbp_pkg::FUNC_ALIGN, 16'h0000, 5'd0);
        send_code(mbp_pkg::FUNC_PUSH, 16'h7FFF, 5'd15);
        send_code(mbp_pkg::FUNC_ALIGN, 16'hFFFF, 5'd16);
    endtask

    // The sender stops until the block has delivered every byte, then resumes.
    task automatic test_pause_until_empty();
        send_code(mbp_pkg::FUNC_PUSH, 16'hFFFF, 5'd16);
        send_code(mbp_pkg::FUNC_PUSH, 16'h0155, 5'd9);
        drain_results();
        send_code(mbp_pkg::FUNC_PUSH, 16'h00FF, 5'd8);
        send_code(mbp_pkg::FUNC_ALIGN, 16'h0000, 5'd0);
    endtask

    task automatic test_random_codes(input int n_items, input logic en,
                                     input int snd_pct, input int rcv_pct);
        int          pick;
        logic        f;
        logic [15:0] code;
        logic [4:0]  cnt;
        write_stuffing(en);
        sender_idle_pct    = snd_pct;
        receiver_stall_pct = rcv_pct;
        for (int i = 0; i < n_items; i++)
        begin
            f    = ($urandom_range(99) < 15) ? mbp_pkg::FUNC_ALIGN : mbp_pkg::FUNC_PUSH;
            pick = $urandom_range(99);
            if (pick < 6)
                cnt = 5'd0;
            else if (pick < 14)
                cnt = 5'($urandom_range(17, 31));
            else
                cnt = 5'($urandom_range(1, 16));
            // All-ones codes make 0xFF bytes, and so stuffing, frequent.
            code = ($urandom_range(99) < 30) ? 16'hFFFF : 16'($urandom);
            send_code(f, code, cnt);
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.stuff_enable = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.func        = mbp_pkg::FUNC_PUSH;
        item_ch.code_bits   = '0;
        item_ch.bit_count   = '0;
        result_ch.ready     = 1'b0;
        pending_bits        = '0;
        pending_count       = 0;
        stuff_on            = 1'b0;
        error_count         = 0;
        cycle_count         = 0;
        sender_idle_pct     = 13;
        receiver_stall_pct  = 45;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_packing();
        test_directed_stuffing();
        test_pause_until_empty();
        test_random_codes(40, 1'b1, 13, 45);
        test_random_codes(40, 1'b0, 45, 13);
        test_random_codes(40, 1'b1, 0, 0);
        drain_results();

        if (error_count == 0 && expected_bytes.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mbp_pkg.sv
hw/rtl/mbp_cfg_if.sv
hw/rtl/mbp_in_if.sv
hw/rtl/mbp_out_if.sv
hw/rtl/mbp_pack.sv
hw/rtl/mbp_emit.sv
hw/rtl/msb_first_bit_packer_with_stuffing.sv
hw/rtl/mbp_checker.sv
tb/msb_first_bit_packer_with_stuffing_tb.sv
